// ----- design/blpw_pkg.sv -----
`default_nettype none

package blpw_pkg;

   // fixed widths of the channel fields
   localparam int PIX_BITS       = 10;
   localparam int ADDR_BITS      = 32;
   localparam int COLOR_BITS     = 24;
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 32;
   localparam int BYTE_SHIFT     = 2;   // four bytes per pixel word

   // opcodes
   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_BASE = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DRAW_COLOR = 8'd1;

   // one pixel write
   typedef struct packed {
      logic [ADDR_BITS-1:0]  pixel_address;
      logic [COLOR_BITS-1:0] pixel_data;
      logic [PIX_BITS-1:0]   pixel_x;
      logic [PIX_BITS-1:0]   pixel_y;
      logic                  last_pixel;
   } pixel_type;

endpackage

`default_nettype wire

// ----- design/blpw_if.sv -----
`default_nettype none

// command channel
interface blpw_req_if;
   import blpw_pkg::*;
   logic                valid;
   logic                ready;
   logic                opcode;
   logic [PIX_BITS-1:0] start_x;
   logic [PIX_BITS-1:0] start_y;
   logic [PIX_BITS-1:0] finish_x;
   logic [PIX_BITS-1:0] finish_y;
   modport source (output valid, opcode, start_x, start_y, finish_x, finish_y, input ready);
   modport sink   (input valid, opcode, start_x, start_y, finish_x, finish_y, output ready);
endinterface

// pixel write channel
interface blpw_rsp_if;
   import blpw_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [ADDR_BITS-1:0]  pixel_address;
   logic [COLOR_BITS-1:0] pixel_data;
   logic [PIX_BITS-1:0]   pixel_x;
   logic [PIX_BITS-1:0]   pixel_y;
   logic                  last_pixel;
   modport source (output valid, pixel_address, pixel_data, pixel_x, pixel_y, last_pixel,
                   input ready);
   modport sink   (input valid, pixel_address, pixel_data, pixel_x, pixel_y, last_pixel,
                   output ready);
endinterface

// register write channel
interface blpw_csr_if;
   import blpw_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- design/blpw_skid.sv -----
`default_nettype none

module blpw_skid (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire blpw_pkg::pixel_type  in_data,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output blpw_pkg::pixel_type       out_data
);
   import blpw_pkg::*;

   logic      out_valid_ff, out_valid_in;
   logic      skid_valid_ff, skid_valid_in;
   pixel_type out_data_ff, out_data_in;
   pixel_type skid_data_ff, skid_data_in;

   // upstream stalls only when the spare slot is taken
   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   // slot routing
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_ready) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || out_ready) begin
         out_valid_in = in_valid;
         out_data_in  = in_data;
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

`default_nettype wire

// ----- design/bresenham_line_pixel_writer.sv -----
`default_nettype none
// Bresenham line engine, all octants, one pixel write per start and per step of an active line.
// A transfer's pixel write is registered in the output register, or in the spare slot when the output stalls.
// Throughput: one command per cycle while the spare output slot is free; the step logic and address
// multiply by the constant pitch sit in a single stage, and a two-slot output stage absorbs stalls.
// Reset clears the line state, both registers and all valid flags; the engine is idle.

module bresenham_line_pixel_writer #(
   parameter int LINE_PITCH = 800,
   parameter int COORD_BITS = 10
) (
   input  wire logic clock,
   input  wire logic reset,
   blpw_req_if.sink   req_bus,
   blpw_rsp_if.source rsp_bus,
   blpw_csr_if.sink   csr_bus
);
   import blpw_pkg::*;

   localparam int ERR_BITS   = COORD_BITS + 2;
   localparam int EW         = ERR_BITS + 2;
   localparam int WIDE       = (COORD_BITS > PIX_BITS) ? COORD_BITS : PIX_BITS;
   localparam int PITCH_BITS = $clog2(LINE_PITCH + 1);
   localparam int ROW_BITS   = COORD_BITS + PITCH_BITS;

   // configuration registers
   logic [ADDR_BITS-1:0]  frame_base_ff;
   logic [COLOR_BITS-1:0] draw_color_ff;

   // line state
   logic [COORD_BITS-1:0]      pos_x_ff, pos_y_ff, goal_x_ff, goal_y_ff;
   logic [COORD_BITS-1:0]      span_x_ff, span_y_ff;
   logic signed [ERR_BITS-1:0] error_term_ff;
   logic                       dir_x_neg_ff, dir_y_neg_ff, line_active_ff;

   logic [COORD_BITS-1:0]      pos_x_in, pos_y_in, goal_x_in, goal_y_in;
   logic [COORD_BITS-1:0]      span_x_in, span_y_in;
   logic signed [ERR_BITS-1:0] error_term_in;
   logic                       dir_x_neg_in, dir_y_neg_in, line_active_in;

   logic                  accept, is_start, last;
   logic                  res_valid, res_ready;
   pixel_type             res_data, out_data;
   logic [WIDE-1:0]       wide_sx, wide_sy, wide_gx, wide_gy, wide_px, wide_py;
   logic [COORD_BITS-1:0] sx, sy, gx, gy;
   logic signed [EW-1:0]  e2, ext_sx, ext_sy, err_sum;
   logic                  move_x, move_y;
   logic [ROW_BITS-1:0]   row_off;
   logic [ADDR_BITS-1:0]  pix_off;

   // register writes
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_base_ff <= '0;
         draw_color_ff <= '0;
      end else if (csr_bus.valid) begin
         if (csr_bus.index == CSR_FRAME_BASE) begin
            frame_base_ff <= csr_bus.data;
         end else if (csr_bus.index == CSR_DRAW_COLOR) begin
            draw_color_ff <= csr_bus.data[COLOR_BITS-1:0];
         end
      end
   end

   // command transfer
   assign accept   = req_bus.valid && req_bus.ready;
   assign is_start = (req_bus.opcode == OP_START);

   // endpoints taken modulo the coordinate range
   assign wide_sx = WIDE'(req_bus.start_x);
   assign wide_sy = WIDE'(req_bus.start_y);
   assign wide_gx = WIDE'(req_bus.finish_x);
   assign wide_gy = WIDE'(req_bus.finish_y);
   assign sx = wide_sx[COORD_BITS-1:0];
   assign sy = wide_sy[COORD_BITS-1:0];
   assign gx = wide_gx[COORD_BITS-1:0];
   assign gy = wide_gy[COORD_BITS-1:0];

   // one bresenham iteration on the held state
   assign e2     = EW'(error_term_ff) <<< 1;
   assign ext_sx = $signed(EW'(span_x_ff));
   assign ext_sy = $signed(EW'(span_y_ff));
   assign move_x = e2 > -ext_sy;
   assign move_y = e2 < ext_sx;
   assign err_sum = EW'(error_term_ff) - (move_x ? ext_sy : '0) + (move_y ? ext_sx : '0);

   // next state
   always_comb begin
      pos_x_in       = pos_x_ff;
      pos_y_in       = pos_y_ff;
      goal_x_in      = goal_x_ff;
      goal_y_in      = goal_y_ff;
      span_x_in      = span_x_ff;
      span_y_in      = span_y_ff;
      error_term_in  = error_term_ff;
      dir_x_neg_in   = dir_x_neg_ff;
      dir_y_neg_in   = dir_y_neg_ff;
      if (is_start) begin
         pos_x_in      = sx;
         pos_y_in      = sy;
         goal_x_in     = gx;
         goal_y_in     = gy;
         dir_x_neg_in  = !(sx < gx);
         dir_y_neg_in  = !(sy < gy);
         span_x_in     = (sx < gx) ? gx - sx : sx - gx;
         span_y_in     = (sy < gy) ? gy - sy : sy - gy;
         error_term_in = ERR_BITS'($signed(EW'(span_x_in)) - $signed(EW'(span_y_in)));
      end else begin
         if (move_x) begin
            pos_x_in = dir_x_neg_ff ? pos_x_ff - 1'b1 : pos_x_ff + 1'b1;
         end
         if (move_y) begin
            pos_y_in = dir_y_neg_ff ? pos_y_ff - 1'b1 : pos_y_ff + 1'b1;
         end
         error_term_in = ERR_BITS'(err_sum);
      end
      last           = (pos_x_in == goal_x_in) && (pos_y_in == goal_y_in);
      line_active_in = !last;
   end

   assign res_valid = accept && (is_start || line_active_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff       <= '0;
         pos_y_ff       <= '0;
         goal_x_ff      <= '0;
         goal_y_ff      <= '0;
         span_x_ff      <= '0;
         span_y_ff      <= '0;
         error_term_ff  <= '0;
         dir_x_neg_ff   <= 1'b0;
         dir_y_neg_ff   <= 1'b0;
         line_active_ff <= 1'b0;
      end else if (res_valid) begin
         pos_x_ff       <= pos_x_in;
         pos_y_ff       <= pos_y_in;
         goal_x_ff      <= goal_x_in;
         goal_y_ff      <= goal_y_in;
         span_x_ff      <= span_x_in;
         span_y_ff      <= span_y_in;
         error_term_ff  <= error_term_in;
         dir_x_neg_ff   <= dir_x_neg_in;
         dir_y_neg_ff   <= dir_y_neg_in;
         line_active_ff <= line_active_in;
      end
   end

   // pixel address: base plus four times the linear offset
   assign row_off = ROW_BITS'(pos_y_in) * ROW_BITS'(LINE_PITCH);
   assign pix_off = ADDR_BITS'(row_off) + ADDR_BITS'(pos_x_in);
   assign wide_px = WIDE'(pos_x_in);
   assign wide_py = WIDE'(pos_y_in);

   always_comb begin
      res_data.pixel_address = frame_base_ff + (pix_off << BYTE_SHIFT);
      res_data.pixel_data    = draw_color_ff;
      res_data.pixel_x       = wide_px[PIX_BITS-1:0];
      res_data.pixel_y       = wide_py[PIX_BITS-1:0];
      res_data.last_pixel    = last;
   end

   // output register with spare slot
   blpw_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_ready  (res_ready),
      .in_data   (res_data),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (out_data)
   );

   assign req_bus.ready         = res_ready;
   assign rsp_bus.pixel_address = out_data.pixel_address;
   assign rsp_bus.pixel_data    = out_data.pixel_data;
   assign rsp_bus.pixel_x       = out_data.pixel_x;
   assign rsp_bus.pixel_y       = out_data.pixel_y;
   assign rsp_bus.last_pixel    = out_data.last_pixel;

endmodule

`default_nettype wire

// ----- dv/bresenham_line_pixel_writer_tb.sv -----
`default_nettype none

module bresenham_line_pixel_writer_tb;
   import blpw_pkg::*;

   localparam int LINE_PITCH   = 800;
   localparam int COORD_BITS   = 10;
   localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
   localparam int DRAIN_CYCLES = 8;
   localparam int RUN_LIMIT    = 3_000_000;

   // indexes past the register list, writes there are dropped
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PAST_END  = CSR_DRAW_COLOR + 1'b1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TOP_INDEX = '1;

   typedef struct packed {
      logic                opcode;
      logic [PIX_BITS-1:0] start_x;
      logic [PIX_BITS-1:0] start_y;
      logic [PIX_BITS-1:0] finish_x;
      logic [PIX_BITS-1:0] finish_y;
   } line_cmd_type;

   logic clock = 1'b0;
   logic reset;

   blpw_req_if req_bus ();
   blpw_rsp_if rsp_bus ();
   blpw_csr_if csr_bus ();

   bresenham_line_pixel_writer #(
      .LINE_PITCH (LINE_PITCH),
      .COORD_BITS (COORD_BITS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #2 clock = ~clock;

   // commands waiting to go out and pixel writes waiting to come back
   line_cmd_type cmd_queue[$];
   pixel_type    pixel_expect[$];
   int           fail_count = 0;

   // idling switches, changed between phases
   bit req_idle_on = 1'b0;
   bit rsp_idle_on = 1'b0;

   // predicted engine state and registers
   logic [ADDR_BITS-1:0]  frame_base = '0;
   logic [COLOR_BITS-1:0] draw_color = '0;
   logic [PIX_BITS-1:0]   cur_x = '0, cur_y = '0, end_x = '0, end_y = '0;
   logic [PIX_BITS-1:0]   span_w = '0, span_h = '0;
   logic signed [COORD_BITS+1:0] err_acc = '0;
   logic x_back = 1'b0, y_back = 1'b0, drawing = 1'b0;

   // mostly short gaps, now and then a long one
   function automatic int pick_gap(input bit enabled);
      int r;
      if (!enabled) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   // advance the predicted line by one command and queue the pixel it writes
   task automatic trace_pixel(input line_cmd_type cmd);
      pixel_type            px;
      logic                 at_end;
      logic [ADDR_BITS-1:0] offset;
      int                   e2, err_next;
      if (cmd.opcode == OP_START) begin
         cur_x   = cmd.start_x;
         cur_y   = cmd.start_y;
         end_x   = cmd.finish_x;
         end_y   = cmd.finish_y;
         x_back  = !(cur_x < end_x);
         y_back  = !(cur_y < end_y);
         span_w  = x_back ? cur_x - end_x : end_x - cur_x;
         span_h  = y_back ? cur_y - end_y : end_y - cur_y;
         err_next = int'(span_w) - int'(span_h);
         err_acc = err_next[COORD_BITS+1:0];
         at_end  = (cur_x == end_x) && (cur_y == end_y);
         drawing = !at_end;
      end else begin
         // step while idle writes nothing
         if (!drawing) return;
         e2       = 2 * int'(err_acc);
         err_next = int'(err_acc);
         if (e2 > -int'(span_h)) begin
            err_next = err_next - int'(span_h);
            cur_x    = x_back ? cur_x - 10'd1 : cur_x + 10'd1;
         end
         if (e2 < int'(span_w)) begin
            err_next = err_next + int'(span_w);
            cur_y    = y_back ? cur_y - 10'd1 : cur_y + 10'd1;
         end
         err_acc = err_next[COORD_BITS+1:0];
         at_end  = (cur_x == end_x) && (cur_y == end_y);
         if (at_end) drawing = 1'b0;
      end
      offset           = ADDR_BITS'(cur_y) * ADDR_BITS'(LINE_PITCH) + ADDR_BITS'(cur_x);
      px.pixel_address = frame_base + (offset << BYTE_SHIFT);
      px.pixel_data    = draw_color;
      px.pixel_x       = cur_x;
      px.pixel_y       = cur_y;
      px.last_pixel    = at_end;
      pixel_expect.push_back(px);
   endtask

   // command driver
   line_cmd_type cmd_now  = '0;
   bit           cmd_held = 1'b0;
   int           cmd_gap  = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         cmd_held = 1'b0;
         cmd_gap  = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            trace_pixel(cmd_now);
            cmd_held = 1'b0;
            cmd_gap  = pick_gap(req_idle_on);
         end
         if (!cmd_held) begin
            if (cmd_gap > 0) begin
               cmd_gap--;
            end else if (cmd_queue.size() != 0) begin
               cmd_now  = cmd_queue.pop_front();
               cmd_held = 1'b1;
            end
         end
         req_bus.valid    <= cmd_held;
         req_bus.opcode   <= cmd_now.opcode;
         req_bus.start_x  <= cmd_now.start_x;
         req_bus.start_y  <= cmd_now.start_y;
         req_bus.finish_x <= cmd_now.finish_x;
         req_bus.finish_y <= cmd_now.finish_y;
      end
   end

   // pixel write sink with random back-pressure
   int stall_left = 0;

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (rsp_idle_on && $urandom_range(0, 3) == 0) stall_left = pick_gap(1'b1);
      end
   end

   function automatic void check_field(input string what, input logic [31:0] want_v,
                                       input logic [31:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want_v, got_v);
         fail_count++;
      end
   endfunction

   // pixel write monitor
   pixel_type want;

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pixel_expect.size() == 0) begin
            $display("%0t: pixel write mismatch, expected none, got addr %0h at (%0d,%0d)",
                     $time, rsp_bus.pixel_address, rsp_bus.pixel_x, rsp_bus.pixel_y);
            fail_count++;
         end else begin
            want = pixel_expect.pop_front();
            check_field("pixel_address", want.pixel_address, rsp_bus.pixel_address);
            check_field("pixel_data", 32'(want.pixel_data), 32'(rsp_bus.pixel_data));
            check_field("pixel_x", 32'(want.pixel_x), 32'(rsp_bus.pixel_x));
            check_field("pixel_y", 32'(want.pixel_y), 32'(rsp_bus.pixel_y));
            check_field("last_pixel", 32'(want.last_pixel), 32'(rsp_bus.last_pixel));
         end
      end
   end

   // register write, one transfer then the channel goes quiet
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      if (idx == CSR_FRAME_BASE) frame_base = value;
      else if (idx == CSR_DRAW_COLOR) draw_color = value[COLOR_BITS-1:0];
      @(posedge clock);
   endtask

   // wait until every command went out and every pixel came back
   task automatic drain_pixels();
      while (cmd_queue.size() != 0 || cmd_held || pixel_expect.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // a start followed by a number of steps
   task automatic queue_line(input int sx, input int sy, input int fx, input int fy,
                             input int steps);
      line_cmd_type cmd;
      cmd.opcode   = OP_START;
      cmd.start_x  = sx[PIX_BITS-1:0];
      cmd.start_y  = sy[PIX_BITS-1:0];
      cmd.finish_x = fx[PIX_BITS-1:0];
      cmd.finish_y = fy[PIX_BITS-1:0];
      cmd_queue.push_back(cmd);
      cmd.opcode = OP_STEP;
      repeat (steps) begin
         // endpoint fields are junk on a step
         cmd.start_x  = PIX_BITS'($urandom());
         cmd.start_y  = PIX_BITS'($urandom());
         cmd.finish_x = PIX_BITS'($urandom());
         cmd.finish_y = PIX_BITS'($urandom());
         cmd_queue.push_back(cmd);
      end
   endtask

   function automatic int clamp_coord(input int v);
      if (v < 0) return 0;
      if (v > COORD_MAX) return COORD_MAX;
      return v;
   endfunction

   function automatic int pick_coord();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 0;
      if (r == 1) return COORD_MAX;
      return $urandom_range(0, COORD_MAX);
   endfunction

   // mostly complete lines in all octants, some cut short, some idle steps
   task automatic queue_random_lines(input int budget);
      int placed, kind, reach, sx, sy, fx, fy, n, cut, extra;
      placed = 0;
      while (placed < budget) begin
         kind  = $urandom_range(0, 19);
         reach = $urandom_range(0, 99);
         reach = (reach < 80) ? 8 : (reach < 97) ? 60 : 300;
         sx = pick_coord();
         sy = pick_coord();
         fx = clamp_coord(sx + $urandom_range(0, 2 * reach) - reach);
         fy = clamp_coord(sy + $urandom_range(0, 2 * reach) - reach);
         if ($urandom_range(0, 14) == 0) begin
            fx = sx;
            fy = sy;
         end
         n = (fx > sx ? fx - sx : sx - fx);
         if ((fy > sy ? fy - sy : sy - fy) > n) n = (fy > sy ? fy - sy : sy - fy);
         if (kind == 0) begin
            // lone step, often hitting an idle engine
            queue_line(sx, sy, fx, fy, 0);
            void'(cmd_queue.pop_back());
            cmd_queue.push_back('{opcode: OP_STEP, default: '0});
            placed += 1;
         end else if (kind <= 3) begin
            // abandoned line, the next start cuts it off
            cut = (n == 0) ? 0 : $urandom_range(0, n - 1);
            queue_line(sx, sy, fx, fy, cut);
            placed += 1 + cut;
         end else begin
            extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0;
            queue_line(sx, sy, fx, fy, n + extra);
            placed += 1 + n + extra;
         end
      end
   endtask

   initial begin
      #(RUN_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.opcode   = OP_START;
      req_bus.start_x  = '0;
      req_bus.start_y  = '0;
      req_bus.finish_x = '0;
      req_bus.finish_y = '0;
      rsp_bus.ready    = 1'b0;
      csr_bus.valid    = 1'b0;
      csr_bus.index    = '0;
      csr_bus.data     = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: idle steps, single-pixel lines, corners, abandoned line
      cmd_queue.push_back('{opcode: OP_STEP, default: '0});
      queue_line(0, 0, 0, 0, 0);
      queue_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0);
      cmd_queue.push_back('{opcode: OP_STEP, default: '1});
      queue_line(COORD_MAX, COORD_MAX, COORD_MAX - 2, COORD_MAX - 1, 3);
      queue_line(0, COORD_MAX, 3, COORD_MAX - 3, 3);
      queue_line(512, 341, 0, 682, 1);
      queue_line(5, 10, 5, 6, 4);
      queue_line(COORD_MAX - 3, 0, COORD_MAX, 0, 3);
      drain_pixels();

      // extreme registers, writes past the list, no idling on either side
      write_reg(CSR_FRAME_BASE, '1);
      write_reg(CSR_DRAW_COLOR, 32'h00FF_FFFF);
      write_reg(CSR_PAST_END, $urandom());
      write_reg(CSR_TOP_INDEX, $urandom());
      queue_random_lines(70);
      drain_pixels();

      // random registers, idling on both sides
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      write_reg(CSR_FRAME_BASE, $urandom());
      write_reg(CSR_DRAW_COLOR, $urandom());
      queue_random_lines(70);
      drain_pixels();

      // base close to the top so addresses wrap, upper data bits dropped
      rsp_idle_on = 1'b0;
      write_reg(CSR_FRAME_BASE, 32'hFFFF_F000);
      write_reg(CSR_DRAW_COLOR, 32'hFF00_0000);
      queue_random_lines(70);
      drain_pixels();

      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      write_reg(CSR_DRAW_COLOR, $urandom());
      write_reg(CSR_FRAME_BASE, $urandom());
      queue_random_lines(70);
      drain_pixels();

      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
